// ===== sv/psvg_pkg.sv =====
// ----------------------------------------------------------------------------
// psvg_pkg: shared types and constants of the polygon / star vertex generator
// Holds the controller states, the command and status structs, and the
// CORDIC angle table.
// ----------------------------------------------------------------------------
package psvg_pkg;

  localparam int AngleLen = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PHASE,
    ST_ROTATE,
    ST_MULT,
    ST_PLACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic phase_start;
    logic rot_start;
    logic mult;
    logic place;
    logic next_vertex;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic phase_done;
    logic rot_done;
    logic last_vertex;
  } status_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] v;
    begin
      case (k)
        5'd0: v = 32'h20000000;
        5'd1: v = 32'h12E4051E;
        5'd2: v = 32'h09FB385B;
        5'd3: v = 32'h051111D4;
        5'd4: v = 32'h028B0D43;
        5'd5: v = 32'h0145D7E1;
        5'd6: v = 32'h00A2F61E;
        5'd7: v = 32'h00517C55;
        5'd8: v = 32'h0028BE53;
        5'd9: v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return v;
    end
  endfunction

  // Q30 CORDIC gain root, floor(sqrt(prod(1 + 2^-2k))); the inverse is taken
  // where it is used.
  function automatic logic [63:0] gain_root(input int iters);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    begin
      p = 64'd1 << 60;
      for (int k = 0; k < iters && k < AngleLen; k++) p = p + (p >> (2 * k));
      r = '0;
      b = 64'd1 << 62;
      v = p;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    end
  endfunction

endpackage

// ===== sv/psvg_ctrl.sv =====
// ----------------------------------------------------------------------------
// psvg_ctrl: sequencer of the vertex generator
// Steps each vertex through phase division, CORDIC, multiply and place.
// ----------------------------------------------------------------------------
module psvg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  psvg_pkg::status_t status,
  output psvg_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              emit
);

  psvg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= psvg_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psvg_pkg::ST_IDLE:   if (in_fire) state_next = psvg_pkg::ST_SETUP;
      psvg_pkg::ST_SETUP:  state_next = status.skip ? psvg_pkg::ST_IDLE : psvg_pkg::ST_PHASE;
      psvg_pkg::ST_PHASE:  if (status.phase_done) state_next = psvg_pkg::ST_ROTATE;
      psvg_pkg::ST_ROTATE: if (status.rot_done) state_next = psvg_pkg::ST_MULT;
      psvg_pkg::ST_MULT:   state_next = psvg_pkg::ST_PLACE;
      psvg_pkg::ST_PLACE:  state_next = psvg_pkg::ST_EMIT;
      psvg_pkg::ST_EMIT:
        if (out_free) state_next = status.last_vertex ? psvg_pkg::ST_IDLE : psvg_pkg::ST_PHASE;
      default: state_next = psvg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    emit = 1'b0;
    unique case (state)
      psvg_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      psvg_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        cmd.phase_start = !status.skip;
      end
      psvg_pkg::ST_PHASE:  cmd.rot_start = status.phase_done;
      psvg_pkg::ST_ROTATE: cmd.mult = status.rot_done;
      psvg_pkg::ST_MULT:   cmd.place = 1'b1;
      psvg_pkg::ST_PLACE:  emit = 1'b0;
      psvg_pkg::ST_EMIT: begin
        emit = out_free;
        cmd.next_vertex = out_free && !status.last_vertex;
        cmd.phase_start = out_free && !status.last_vertex;
      end
      default: busy = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    state == psvg_pkg::ST_IDLE |-> !emit) else $error("emit while idle");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == psvg_pkg::ST_IDLE) else $error("load while busy");
  a_setup_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == psvg_pkg::ST_SETUP) else $error("no setup after load");
`endif

endmodule

// ===== sv/psvg_datapath.sv =====
// ----------------------------------------------------------------------------
// psvg_datapath: geometry, phase divider, CORDIC and placement
// Restoring divider for the phase, one bit a cycle; CORDIC one step a cycle;
// one (COORD_WIDTH+2) x 32 multiply per axis, registered before rounding.
// ----------------------------------------------------------------------------
module psvg_datapath #(
  parameter int MAX_COUNT    = 32,
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_ITERS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  psvg_pkg::cmd_t               cmd,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic                         centered,
  input  logic                         uniform,
  input  logic [5:0]                   count,
  input  logic                         star,
  output psvg_pkg::status_t            status,
  output logic signed [COORD_WIDTH:0] point_x,
  output logic signed [COORD_WIDTH:0] point_y,
  output logic [5:0]                   vertex_index,
  output logic                         last
);

  localparam int CW = COORD_WIDTH + 2;   // centers and radii, 1/32 pixel
  localparam logic [63:0] GR = psvg_pkg::gain_root(CORDIC_ITERS);
  localparam logic [31:0] KQ = 32'(((64'd1 << 60) + GR / 2) / GR);
  localparam int IW = $clog2(CORDIC_ITERS + 1);

  logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey;
  logic fc, un, st;
  logic [5:0] cnt;
  logic signed [CW-1:0] cx2, cy2;
  logic [CW-1:0] rx2, ry2;
  logic [6:0] m, vi;
  logic skip;

  // setup arithmetic
  logic signed [CW-1:0] dxs, dys;
  logic [CW-1:0] adx, ady, rxa, rya, rmax;
  logic [5:0] cclamp;
  logic [6:0] m_setup;
  always_comb begin
    dxs = CW'(ex) - CW'(sx);
    dys = CW'(ey) - CW'(sy);
    adx = dxs[CW-1] ? CW'(-dxs) : dxs;
    ady = dys[CW-1] ? CW'(-dys) : dys;
    rxa = fc ? (adx << 1) : adx;
    rya = fc ? (ady << 1) : ady;
    rmax = (rxa > rya) ? rxa : rya;
    cclamp = (cnt > 6'(MAX_COUNT)) ? 6'(MAX_COUNT) : cnt;
    m_setup = st ? {cclamp, 1'b0} : {1'b0, cclamp};
  end
  assign status.skip = skip;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= start_x; sy <= start_y; ex <= end_x; ey <= end_y;
      fc <= centered; un <= uniform; st <= star; cnt <= count;
    end
    if (cmd.setup) begin
      cx2 <= fc ? (CW'(sx) <<< 1) : CW'(sx) + CW'(ex);
      cy2 <= fc ? (CW'(sy) <<< 1) : CW'(sy) + CW'(ey);
      rx2 <= un ? rmax : rxa;
      ry2 <= un ? rmax : rya;
      m <= m_setup;
      vi <= '0;
    end
    if (cmd.next_vertex) vi <= vi + 7'd1;
  end

  always_comb begin
    skip = (cnt < 6'd3) || ((un ? rmax : rxa) <= CW'(3)) || ((un ? rmax : rya) <= CW'(3));
  end

  // phase divider: t = (vi*2^32 + m/2) / m, restoring, one bit a cycle
  logic [5:0] dcnt;
  logic dbusy;
  always_ff @(posedge clk) begin
    if (rst) dbusy <= 1'b0;
    else if (cmd.phase_start) dbusy <= 1'b1;
    else if (dbusy && dcnt == 6'd38) dbusy <= 1'b0;
    if (cmd.phase_start) begin
      dcnt <= '0;
    end else if (dbusy) begin
      dcnt <= dcnt + 6'd1;
    end
  end
  // keep the full dividend in a shift register, quotient bits enter at the bottom
  logic [38:0] dvd;
  logic [38:0] dvd_next;
  logic [38:0] rq;
  logic [39:0] tr;
  logic [6:0] m_div, vi_start;
  always_comb begin
    // the first vertex starts while m and vi are still being loaded
    m_div = cmd.setup ? m_setup : m;
    vi_start = cmd.setup ? 7'd0 : (cmd.next_vertex ? vi + 7'd1 : vi);
    dvd_next = {vi_start, 32'd0} + 39'(m_div >> 1);
    tr = {rq, dvd[38]} - {33'd0, m};
  end
  always_ff @(posedge clk) begin
    if (cmd.phase_start) begin
      dvd <= dvd_next;
      rq <= '0;
    end else if (dbusy) begin
      dvd <= {dvd[37:0], !tr[39]};
      rq <= tr[39] ? {rq[37:0], dvd[38]} : tr[38:0];
    end
  end
  assign status.phase_done = dbusy && dcnt == 6'd38;
  logic [31:0] phase;
  always_comb phase = {dvd[30:0], !tr[39]};

  // CORDIC, one step a cycle
  logic signed [33:0] z;
  logic signed [33:0] cxr, cyr;
  logic flip;
  logic [IW-1:0] it;
  logic rbusy;
  logic signed [33:0] z0;
  logic [4:0] it5;
  always_comb begin
    z0 = {2'b00, phase};
    if (z0 >= (34'sd1 <<< 31)) z0 = z0 - (34'sd1 <<< 32);
    it5 = 5'(it);
  end
  always_ff @(posedge clk) begin
    if (rst) rbusy <= 1'b0;
    else if (cmd.rot_start) rbusy <= 1'b1;
    else if (rbusy && it == IW'(CORDIC_ITERS - 1)) rbusy <= 1'b0;
    if (cmd.rot_start) begin
      cxr <= 34'(KQ);
      cyr <= '0;
      it <= '0;
      if (z0 > (34'sd1 <<< 30)) begin
        z <= z0 - (34'sd1 <<< 31); flip <= 1'b1;
      end else if (z0 < -(34'sd1 <<< 30)) begin
        z <= z0 + (34'sd1 <<< 31); flip <= 1'b1;
      end else begin
        z <= z0; flip <= 1'b0;
      end
    end else if (rbusy) begin
      it <= it + 1'b1;
      if (!z[33]) begin
        cxr <= cxr - (cyr >>> it5);
        cyr <= cyr + (cxr >>> it5);
        z <= z - 34'(psvg_pkg::atan_entry(it5));
      end else begin
        cxr <= cxr + (cyr >>> it5);
        cyr <= cyr - (cxr >>> it5);
        z <= z + 34'(psvg_pkg::atan_entry(it5));
      end
    end
  end
  assign status.rot_done = rbusy && it == IW'(CORDIC_ITERS - 1);

  // multiply: s for x, -c for y
  logic signed [33:0] sv_last, cv_last, sval, yval;
  always_comb begin
    sv_last = (!z[33]) ? cyr + (cxr >>> it5) : cyr - (cxr >>> it5);
    cv_last = (!z[33]) ? cxr - (cyr >>> it5) : cxr + (cyr >>> it5);
    sval = flip ? -sv_last : sv_last;
    yval = flip ? cv_last : -cv_last;
  end
  logic [31:0] magx, magy;
  logic negx, negy, inner;
  logic [CW+31:0] px, py;
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      negx <= sval[33];
      negy <= yval[33];
      magx <= 32'(sval[33] ? -sval : sval);
      magy <= 32'(yval[33] ? -yval : yval);
      inner <= st && vi[0];
    end
    if (cmd.place) begin
      px <= (CW+32)'(rx2) * (CW+32)'(magx);
      py <= (CW+32)'(ry2) * (CW+32)'(magy);
    end
  end

  // round, add center, saturate
  function automatic logic signed [COORD_WIDTH:0] finish(
      input logic signed [CW-1:0] c, input logic [CW+31:0] p,
      input logic neg, input logic inn);
    logic [CW+31:0] off;
    logic signed [CW+2:0] s;
    logic signed [CW+2:0] h;
    begin
      off = inn ? ((p + (CW+32)'(64'd1 << 30)) >> 31) : ((p + (CW+32)'(64'd1 << 29)) >> 30);
      s = (CW+3)'(c) + (neg ? -(CW+3)'(off) : (CW+3)'(off)) + (CW+3)'(1);
      h = s >>> 1;
      if (h > (CW+3)'((64'sd1 <<< COORD_WIDTH) - 1))
        return {1'b0, {COORD_WIDTH{1'b1}}};
      else if (h < -((CW+3)'(64'sd1 <<< COORD_WIDTH)))
        return {1'b1, {COORD_WIDTH{1'b0}}};
      return (COORD_WIDTH+1)'(h);
    end
  endfunction

  logic signed [COORD_WIDTH:0] pxo, pyo;
  logic [5:0] vio;
  logic lo;
  always_ff @(posedge clk) begin
    pxo <= finish(cx2, px, negx, inner);
    pyo <= finish(cy2, py, negy, inner);
    vio <= 6'(vi);
    lo <= (vi == m - 7'd1);
  end
  assign point_x = pxo;
  assign point_y = pyo;
  assign vertex_index = vio;
  assign last = lo;
  assign status.last_vertex = (vi == m - 7'd1);

`ifndef SYNTHESIS
  a_div_rot: assert property (@(posedge clk) disable iff (rst)
    !(dbusy && rbusy)) else $error("divider and cordic both busy");
  a_vi_range: assert property (@(posedge clk) disable iff (rst)
    rbusy |-> vi < m) else $error("vertex index past count");
  a_rot_end: assert property (@(posedge clk) disable iff (rst)
    status.rot_done |=> !rbusy) else $error("cordic overrun");
`endif

endmodule

// ===== sv/polygon_star_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// polygon_star_vertex_generator_top
// Regular polygon and star vertex generator.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word describes a drag box and a shape. Output
// stream m_axis: one word per vertex, tlast on the final vertex.
// A word is accepted only while the block is idle. Count below 3, or a
// radius under 0.1 pixel, gives no output and the block returns to idle.
// Per vertex: phase division (one quotient bit per cycle), CORDIC rotation,
// a multiply and a placement, then the vertex is presented.
// A stalled receiver holds the vertex in the output register; the next
// vertex is computed and then waits until the held one is taken. Reset
// returns to idle and drops any shape in flight.
// ----------------------------------------------------------------------------
module polygon_star_vertex_generator_top #(
  parameter int MAX_COUNT    = 32,
  parameter int COORD_WIDTH  = 20,
  parameter int CORDIC_ITERS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, centered, uniform, count, star
  input  logic [((4*COORD_WIDTH+9+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // point_x, point_y, vertex_index
  output logic [((2*COORD_WIDTH+8+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int W = COORD_WIDTH;
  localparam int OW = ((2*COORD_WIDTH+8+7)/8)*8;

  psvg_pkg::cmd_t cmd;
  psvg_pkg::status_t status;
  logic busy, emit, in_fire, ovalid;
  logic signed [W:0] px, py;
  logic [5:0] vidx;
  logic lst;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  psvg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!ovalid || m_axis_tready),
    .status(status), .cmd(cmd), .busy(busy), .emit(emit)
  );

  psvg_datapath #(
    .MAX_COUNT(MAX_COUNT), .COORD_WIDTH(COORD_WIDTH), .CORDIC_ITERS(CORDIC_ITERS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .start_x(s_axis_tdata[W-1:0]), .start_y(s_axis_tdata[2*W-1:W]),
    .end_x(s_axis_tdata[3*W-1:2*W]), .end_y(s_axis_tdata[4*W-1:3*W]),
    .centered(s_axis_tdata[4*W]), .uniform(s_axis_tdata[4*W+1]),
    .count(s_axis_tdata[4*W+7:4*W+2]), .star(s_axis_tdata[4*W+8]),
    .status(status), .point_x(px), .point_y(py), .vertex_index(vidx), .last(lst)
  );

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (emit) ovalid <= 1'b1;
    else if (m_axis_tready) ovalid <= 1'b0;
    if (emit) begin
      m_axis_tdata <= OW'({vidx, py, px});
      m_axis_tlast <= lst;
    end
  end
  assign m_axis_tvalid = ovalid;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("accepted word without starting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("word changed");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !emit) else $error("emit while idle");
`endif

endmodule
